@@ hdl/bbr_pkg.sv @@
`default_nettype none

package bbr_pkg;

    // Frame limits
    localparam int MAX_WIDTH    = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int HEIGHT_RESET = 1024;

    // Field and counter widths
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int COL_W      = 10;
    localparam int IN_ROW_W   = 13;
    localparam int OUT_ROW_W  = 12;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Mean: 9 x 255 fits in 12 bits; reciprocal scaled by 2^16
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int RECIP_W   = 17;
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int DIV_SHIFT = 16;

    // Opcodes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pix_t;

    // ceil(2^16 / n): exact floor division for 12-bit dividends and n <= 9
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            CNT_W'(1): r = RECIP_W'(65536);
            CNT_W'(2): r = RECIP_W'(32768);
            CNT_W'(3): r = RECIP_W'(21846);
            CNT_W'(4): r = RECIP_W'(16384);
            CNT_W'(5): r = RECIP_W'(13108);
            CNT_W'(6): r = RECIP_W'(10923);
            CNT_W'(7): r = RECIP_W'(9363);
            CNT_W'(8): r = RECIP_W'(8192);
            CNT_W'(9): r = RECIP_W'(7282);
            default:   r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hdl/bbr_in_if.sv @@
`default_nettype none

interface bbr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [bbr_pkg::CHAN_W-1:0]  red_in;
    logic [bbr_pkg::CHAN_W-1:0]  green_in;
    logic [bbr_pkg::CHAN_W-1:0]  blue_in;

    modport source (
        output valid,
        output opcode,
        output red_in,
        output green_in,
        output blue_in,
        input  ready
    );

    modport sink (
        input  valid,
        input  opcode,
        input  red_in,
        input  green_in,
        input  blue_in,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/bbr_out_if.sv @@
`default_nettype none

interface bbr_out_if;
    logic                        valid;
    logic                        ready;
    logic [bbr_pkg::CHAN_W-1:0]  red_out;
    logic [bbr_pkg::CHAN_W-1:0]  green_out;
    logic [bbr_pkg::CHAN_W-1:0]  blue_out;
    logic                        frame_last;

    modport source (
        output valid,
        output red_out,
        output green_out,
        output blue_out,
        output frame_last,
        input  ready
    );

    modport sink (
        input  valid,
        input  red_out,
        input  green_out,
        input  blue_out,
        input  frame_last,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/bbr_line_ram.sv @@
`default_nettype none

// Both line stores side by side: {upper, middle} per column.
module bbr_line_ram (
    input  wire logic                         clk,
    input  wire logic                         wr_en,
    input  wire logic [bbr_pkg::COL_W-1:0]    wr_addr,
    input  wire logic [bbr_pkg::LINE_W-1:0]   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [bbr_pkg::COL_W-1:0]    rd_addr,
    output logic      [bbr_pkg::LINE_W-1:0]   rd_data
);

    logic [bbr_pkg::LINE_W-1:0] mem [bbr_pkg::MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hdl/box_blur_3x3_rgb.sv @@
// A request that yields a result raises blurred.valid after the read state and the divide state.
// Requests are taken one at a time: line RAM read, read-modify-write plus neighborhood sum,
// then reciprocal multiply when it yields a result; a flush dropped mid-frame skips them all;
// a result the sink holds off keeps the next one and the input waiting.
// Results trail the pixel stream by one row plus one pixel; width + 1 flushes drain it.
// Reset: sizes return to 1024, counters and window clear; the line RAM keeps its contents.
`default_nettype none

module box_blur_3x3_rgb (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [bbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bbr_pkg::CFG_DATA_W-1:0]   cfg_data,
    bbr_in_if.sink                                pixels,
    bbr_out_if.source                             blurred
);

    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for a request, launch the RAM read
    localparam logic [1:0] ST_READ = 2'd1;  // RAM data back: update lines, window, sums
    localparam logic [1:0] ST_DIV  = 2'd2;  // divide sums, load the output register

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [bbr_pkg::WIDTH_W-1:0]  width_reg;
    logic [bbr_pkg::HEIGHT_W-1:0] height_reg;
    logic [bbr_pkg::WIDTH_W-1:0]  w_eff;
    logic [bbr_pkg::HEIGHT_W-1:0] h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bbr_pkg::WIDTH_W'(bbr_pkg::MAX_WIDTH);
            height_reg <= bbr_pkg::HEIGHT_W'(bbr_pkg::HEIGHT_RESET);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bbr_pkg::REG_WIDTH:  width_reg  <= cfg_data[bbr_pkg::WIDTH_W-1:0];
                bbr_pkg::REG_HEIGHT: height_reg <= cfg_data[bbr_pkg::HEIGHT_W-1:0];
                default:             ;
            endcase
        end
    end

    // Zero reads as one, anything above the limit saturates
    always_comb
    begin
        if (width_reg == '0)
            w_eff = bbr_pkg::WIDTH_W'(1);
        else if (width_reg > bbr_pkg::WIDTH_W'(bbr_pkg::MAX_WIDTH))
            w_eff = bbr_pkg::WIDTH_W'(bbr_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;

        if (height_reg == '0)
            h_eff = bbr_pkg::HEIGHT_W'(1);
        else if (height_reg > bbr_pkg::HEIGHT_W'(bbr_pkg::MAX_HEIGHT))
            h_eff = bbr_pkg::HEIGHT_W'(bbr_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    logic [1:0]                    state_reg,     state_next;
    logic [bbr_pkg::COL_W-1:0]     in_col_reg,    in_col_next;
    logic [bbr_pkg::IN_ROW_W-1:0]  in_row_reg,    in_row_next;
    logic [bbr_pkg::COL_W-1:0]     out_col_reg,   out_col_next;
    logic [bbr_pkg::OUT_ROW_W-1:0] out_row_reg,   out_row_next;
    logic                          out_valid_reg, out_valid_next;

    // Payload
    bbr_pkg::pix_t                 pix_reg;
    bbr_pkg::pix_t                 win1_reg [3];   // window column left of the newest one
    bbr_pkg::pix_t                 win2_reg [3];   // newest column already in the window
    logic [bbr_pkg::SUM_W-1:0]     sum_reg  [3];   // red, green, blue
    logic [bbr_pkg::CNT_W-1:0]     cnt_reg;
    logic                          last_reg;
    bbr_pkg::pix_t                 out_pix_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          drain;
    logic                          start;
    logic                          emit;
    logic                          frame_end;
    logic                          restart;
    logic                          out_load;
    logic [bbr_pkg::WIDTH_W-1:0]   in_col_inc;
    logic [bbr_pkg::WIDTH_W-1:0]   out_col_inc;
    logic [bbr_pkg::HEIGHT_W-1:0]  out_row_inc;

    assign accept = pixels.valid && pixels.ready;

    // Once every pixel of the frame is in, any request drains one result
    assign drain = in_row_reg >= bbr_pkg::IN_ROW_W'(h_eff);

    // Flush requests during the frame are dropped on the spot
    assign start = accept && (drain || (pixels.opcode == bbr_pkg::OP_PIXEL));

    assign pixels.ready = (state_reg == ST_IDLE);

    assign in_col_inc  = {1'b0, in_col_reg} + bbr_pkg::WIDTH_W'(1);
    assign out_col_inc = {1'b0, out_col_reg} + bbr_pkg::WIDTH_W'(1);
    assign out_row_inc = {1'b0, out_row_reg} + bbr_pkg::HEIGHT_W'(1);

    // A result is due from the second pixel of the second row on
    assign emit = (in_row_reg >= bbr_pkg::IN_ROW_W'(2)) ||
                  ((in_row_reg == bbr_pkg::IN_ROW_W'(1)) && (in_col_reg != '0));

    assign frame_end = (out_col_inc == w_eff) && (out_row_inc == h_eff);

    // ------------------------------------------------------------------
    // Line RAM: read at the request, write back the shifted column in ST_READ.
    // One request at a time, so the write always lands before the next read.
    // ------------------------------------------------------------------
    logic [bbr_pkg::LINE_W-1:0] ram_rd_data;
    bbr_pkg::pix_t              top_pix;
    bbr_pkg::pix_t              mid_pix;

    // Rows not yet written in this frame read as black
    assign top_pix = (in_row_reg >= bbr_pkg::IN_ROW_W'(2)) ?
                     ram_rd_data[bbr_pkg::LINE_W-1:bbr_pkg::PIX_W] : '0;
    assign mid_pix = (in_row_reg >= bbr_pkg::IN_ROW_W'(1)) ?
                     ram_rd_data[bbr_pkg::PIX_W-1:0] : '0;

    bbr_line_ram u_line_ram (
        .clk     (clk),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (in_col_reg),
        .wr_data ({mid_pix, pix_reg}),
        .rd_en   (start),
        .rd_addr (in_col_reg),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------
    // Neighborhood sum. Columns a, b are the window before the shift; column c is
    // the one arriving now. At input column zero the pending result closes its row,
    // so column c belongs to the next row and is dropped.
    // ------------------------------------------------------------------
    bbr_pkg::pix_t              nb [3][3];
    logic [2:0]                 row_ok;
    logic [2:0]                 col_ok;
    logic [1:0]                 n_rows;
    logic [1:0]                 n_cols;
    logic [bbr_pkg::SUM_W-1:0]  sum_next [3];
    logic [bbr_pkg::CNT_W-1:0]  cnt_next;

    always_comb
    begin
        nb[0][0] = win1_reg[0];
        nb[1][0] = win1_reg[1];
        nb[2][0] = win1_reg[2];
        nb[0][1] = win2_reg[0];
        nb[1][1] = win2_reg[1];
        nb[2][1] = win2_reg[2];
        nb[0][2] = top_pix;
        nb[1][2] = mid_pix;
        nb[2][2] = pix_reg;

        row_ok[0] = (out_row_reg != '0);
        row_ok[1] = 1'b1;
        row_ok[2] = out_row_inc < h_eff;
        col_ok[0] = (out_col_reg != '0);
        col_ok[1] = 1'b1;
        col_ok[2] = (in_col_reg != '0) && (out_col_inc < w_eff);

        n_rows = 2'(row_ok[0]) + 2'(row_ok[2]) + 2'd1;
        n_cols = 2'(col_ok[0]) + 2'(col_ok[2]) + 2'd1;
        cnt_next = {2'b00, n_rows} * {2'b00, n_cols};

        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next[ch] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    sum_next[0] = sum_next[0] + bbr_pkg::SUM_W'(nb[r][c].red);
                    sum_next[1] = sum_next[1] + bbr_pkg::SUM_W'(nb[r][c].green);
                    sum_next[2] = sum_next[2] + bbr_pkg::SUM_W'(nb[r][c].blue);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Divide by multiplying with the scaled reciprocal of the count
    // ------------------------------------------------------------------
    logic [bbr_pkg::PROD_W-1:0] prod [3];
    logic [bbr_pkg::CHAN_W-1:0] quot [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = bbr_pkg::PROD_W'(sum_reg[ch]) *
                       bbr_pkg::PROD_W'(bbr_pkg::recip(cnt_reg));
            quot[ch] = prod[ch][bbr_pkg::DIV_SHIFT +: bbr_pkg::CHAN_W];
        end
    end

    // Load the output register when it is empty or taken this cycle; a result the
    // sink holds off keeps this one in the divide stage and the input waiting
    assign out_load = (state_reg == ST_DIV) && (!out_valid_reg || blurred.ready);

    // ------------------------------------------------------------------
    // Next-state logic
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        in_col_next    = in_col_reg;
        in_row_next    = in_row_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_valid_next = out_valid_reg;
        restart        = 1'b0;

        if (out_load)
            out_valid_next = 1'b1;
        else if (blurred.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                // Advance the input position
                if (in_col_inc >= w_eff)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + bbr_pkg::IN_ROW_W'(1);
                end
                else
                begin
                    in_col_next = in_col_inc[bbr_pkg::COL_W-1:0];
                end

                if (emit)
                begin
                    state_next = ST_DIV;
                    if (frame_end)
                    begin
                        restart = 1'b1;
                    end
                    else if (out_col_inc == w_eff)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + bbr_pkg::OUT_ROW_W'(1);
                    end
                    else
                    begin
                        out_col_next = out_col_inc[bbr_pkg::COL_W-1:0];
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write restarts the frame and drops anything pending
        if (cfg_we)
        begin
            restart        = 1'b1;
            state_next     = ST_IDLE;
            out_valid_next = 1'b0;
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Window: clear on restart, otherwise shift in the new column in the read state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win1_reg[r] <= '0;
                win2_reg[r] <= '0;
            end
        end
        else if (restart)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win1_reg[r] <= '0;
                win2_reg[r] <= '0;
            end
        end
        else if (state_reg == ST_READ)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win1_reg[r] <= win2_reg[r];
                win2_reg[r] <= nb[r][2];
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // Drain requests carry no pixel
            if (drain)
                pix_reg <= '0;
            else
                pix_reg <= '{red: pixels.red_in, green: pixels.green_in,
                             blue: pixels.blue_in};
        end

        if ((state_reg == ST_READ) && emit)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= sum_next[ch];
            end
            cnt_reg  <= cnt_next;
            last_reg <= frame_end;
        end

        if (out_load)
        begin
            out_pix_reg  <= '{red: quot[0], green: quot[1], blue: quot[2]};
            out_last_reg <= last_reg;
        end
    end

    assign blurred.valid      = out_valid_reg;
    assign blurred.red_out    = out_pix_reg.red;
    assign blurred.green_out  = out_pix_reg.green;
    assign blurred.blue_out   = out_pix_reg.blue;
    assign blurred.frame_last = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_in_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, in_col_reg} < w_eff)
        else $error("input column beyond frame width");

    a_out_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, out_col_reg} < w_eff)
        else $error("output column beyond frame width");

    a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) && emit && frame_end |=>
        (in_row_reg == '0) && (in_col_reg == '0) && (out_row_reg == '0))
        else $error("frame did not restart after its last result");

    a_div_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |->
        ($past(state_reg) == ST_READ) || ($past(state_reg) == ST_DIV))
        else $error("divide stage entered without a read stage");

endmodule

`default_nettype wire
